// ===== rtl/rhtfd_pkg.sv =====
// Shared types, constants and the CRC-8 helper for the sensor frame decoder.
// No dependencies; every other file of the block imports this package.

package rhtfd_pkg;

    // Result status codes.
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_KIND = 2'd1;
    localparam logic [1:0] ST_CRC  = 2'd2;
    localparam logic [1:0] ST_ZERO = 2'd3;

    // CRC-8, polynomial x^8+x^5+x^4+1 with the top term implied.
    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam int unsigned KIND_BIT = 1;

    // Scale factors in hundredths, applied as code * scale / 2^16.
    localparam logic [14:0] TEMP_SCALE  = 15'd17572;
    localparam logic [14:0] RH_SCALE    = 15'd12500;
    localparam logic [15:0] TEMP_OFFSET = 16'd4685;
    localparam logic [15:0] RH_OFFSET   = 16'd600;

    localparam int unsigned VALUE_W = 15;
    localparam int unsigned CODE_W  = 16;

    typedef struct packed {
        logic       func;
        logic [7:0] msb_byte;
        logic [7:0] lsb_byte;
        logic [7:0] crc_byte;
    } frame_t;

    // One byte through the MSB-first CRC register.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
        logic [7:0] crc;
        crc = crc_in ^ data;
        for (int i = 0; i < 8; i++)
        begin
            if (crc[7])
            begin
                crc = {crc[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                crc = {crc[6:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

// ===== rtl/rhtfd_check.sv =====
// Frame validation: kind bit, all-zero frame and CRC-8 over the two data bytes.
// Depends on rhtfd_pkg for the frame type, status codes and CRC helper.

module rhtfd_check
    import rhtfd_pkg::*;
(
    input  frame_t     frame,
    output logic [1:0] status
);

    logic [7:0] crc_hi;
    logic [7:0] crc_calc;
    logic       kind_bad;
    logic       all_zero;

    assign crc_hi   = crc8_byte(8'h00, frame.msb_byte);
    assign crc_calc = crc8_byte(crc_hi, frame.lsb_byte);
    assign kind_bad = frame.lsb_byte[KIND_BIT] != frame.func;
    assign all_zero = (frame.msb_byte == 8'h00) && (frame.lsb_byte == 8'h00)
                      && (frame.crc_byte == 8'h00);

    // The kind check wins over the zero check, which wins over the CRC check.
    always_comb
    begin
        if (kind_bad)
        begin
            status = ST_KIND;
        end
        else if (all_zero)
        begin
            status = ST_ZERO;
        end
        else if (crc_calc != frame.crc_byte)
        begin
            status = ST_CRC;
        end
        else
        begin
            status = ST_OK;
        end
    end

endmodule

// ===== rtl/rhtfd_conv.sv =====
// Code extraction and fixed-point conversion to hundredths of a unit.
// Depends on rhtfd_pkg for the frame type and the scale and offset constants.

module rhtfd_conv
    import rhtfd_pkg::*;
(
    input  frame_t               frame,
    output logic [CODE_W-1:0]    raw_code,
    output logic [VALUE_W-1:0]   value
);

    logic [14:0] scale;
    logic [15:0] offset;
    logic [30:0] product;
    logic [15:0] scaled;
    logic [15:0] diff;

    assign raw_code = {frame.msb_byte, frame.lsb_byte[7:2], 2'b00};
    assign scale    = frame.func ? RH_SCALE : TEMP_SCALE;
    assign offset   = frame.func ? RH_OFFSET : TEMP_OFFSET;

    // The product stays below 2^31; dropping 16 bits rounds toward minus infinity.
    assign product = 31'(scale) * 31'(raw_code);
    assign scaled  = {1'b0, product[30:16]};
    assign diff    = scaled - offset;
    assign value   = diff[VALUE_W-1:0];

endmodule

// ===== rtl/rh_temp_sensor_frame_decoder_core.sv =====
// Top level of the sensor frame decoder: input register, check and convert, result register.
// Depends on rhtfd_pkg, rhtfd_check and rhtfd_conv.
//
// Usage:
//   The input channel (in_valid / in_stall) carries one measurement frame per transfer:
//   func selects temperature (0) or humidity (1), and msb_byte, lsb_byte and crc_byte are
//   the three bytes as received from the sensor. The output channel (out_valid /
//   out_stall) returns exactly one result per frame: status, value and raw_code.
//   A transfer happens at a rising edge where valid is high and stall is low.
//
//   A frame taken is held in the input register, checked and converted combinationally
//   from there, and shown from the result register once that register takes it.
//   Throughput is one frame per cycle while out_stall is low, set by the single pass of
//   CRC logic and one 15 by 16 bit multiplier between the two registers.
//
//   When the receiver stalls, the result register holds its transfer unchanged. The
//   input register still fills while the result waits, so one more frame is taken
//   before in_stall rises. in_stall depends only on register state and out_stall.
//
//   Reset (rst_n low, asynchronous) empties both registers; out_valid is low and
//   in_stall is low right after reset. Results that fail a check carry value and
//   raw_code of zero.

module rh_temp_sensor_frame_decoder_core
    import rhtfd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               in_valid,
    output logic               in_stall,
    input  logic               func,
    input  logic [7:0]         msb_byte,
    input  logic [7:0]         lsb_byte,
    input  logic [7:0]         crc_byte,

    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic [VALUE_W-1:0] value,
    output logic [CODE_W-1:0]  raw_code
);

    // Input register stage.
    logic   s1_valid_reg;
    logic   s1_valid_next;
    frame_t s1_frame_reg;
    logic   s1_ready;

    // Result register stage.
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [1:0]         status_reg;
    logic [VALUE_W-1:0] value_reg;
    logic [CODE_W-1:0]  raw_code_reg;
    logic               s2_ready;

    // Combinational results of the single pass.
    logic [1:0]         chk_status;
    logic [VALUE_W-1:0] conv_value;
    logic [CODE_W-1:0]  conv_code;
    logic               ok;

    // The result register can take a new entry when it is empty or being drained.
    assign s2_ready = !out_valid_reg || !out_stall;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_stall = !s1_ready;

    assign s1_valid_next  = s1_ready ? in_valid : s1_valid_reg;
    assign out_valid_next = s2_ready ? s1_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && s1_ready)
        begin
            s1_frame_reg <= '{func: func, msb_byte: msb_byte,
                              lsb_byte: lsb_byte, crc_byte: crc_byte};
        end
    end

    rhtfd_check u_check
    (
        .frame  (s1_frame_reg),
        .status (chk_status)
    );

    rhtfd_conv u_conv
    (
        .frame    (s1_frame_reg),
        .raw_code (conv_code),
        .value    (conv_value)
    );

    // A failed frame reports zero for both value and code.
    assign ok = chk_status == ST_OK;

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s2_ready)
        begin
            status_reg   <= chk_status;
            value_reg    <= ok ? conv_value : '0;
            raw_code_reg <= ok ? conv_code : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign value     = value_reg;
    assign raw_code  = raw_code_reg;

endmodule

// ===== rtl/rhtfd_sva.sv =====
// Port-level checker for the sensor frame decoder, bound to the top level.
// Depends on rhtfd_pkg for status codes and field widths.

module rhtfd_sva
    import rhtfd_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               func,
    input logic [7:0]         msb_byte,
    input logic [7:0]         lsb_byte,
    input logic [7:0]         crc_byte,
    input logic               out_valid,
    input logic               out_stall,
    input logic [1:0]         status,
    input logic [VALUE_W-1:0] value,
    input logic [CODE_W-1:0]  raw_code
);

    // A stalled result transfer holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(value)
                                   && $stable(raw_code))
        else $error("stalled result changed");

    // With the result register empty the input side never stalls.
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled while output empty");

    // Failed frames carry zero value and code.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> value == '0 && raw_code == '0)
        else $error("error result with nonzero payload");

    // Good results have the low code bits cleared and lie in the converted range.
    a_ok_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_OK |-> raw_code[1:0] == 2'b00
            && $signed(value) >= -15'sd4685 && $signed(value) <= 15'sd12885)
        else $error("good result out of range");

endmodule

bind rh_temp_sensor_frame_decoder_core rhtfd_sva u_rhtfd_sva (.*);
